// ----- rtl/mss_pkg.sv -----
// Package for the masked signature scanner: signature value and mask tables,
// tdata widths and the packed result layout. No dependencies.
`timescale 1ns / 1ps

package mss_pkg;

	localparam int TABLE_LEN   = 32;
	localparam int IN_DATA_W   = 64;
	localparam int REC_W       = 140;
	localparam int OUT_DATA_W  = 144;
	localparam int ADDR_W      = 64;
	localparam int CNT_W       = 32;
	localparam int IDX_W       = 5;

	localparam logic REC_KIND_HIT     = 1'b0;
	localparam logic REC_KIND_SUMMARY = 1'b1;

	// Result payload, last field in the lowest bits.
	typedef struct packed {
		logic [CNT_W-1:0]        words_read;
		logic [CNT_W-1:0]        overflow_hits;
		logic [IDX_W-1:0]        stored_hits;
		logic signed [IDX_W-1:0] best_index;
		logic                    hit_stored;
		logic                    hit_strict;
		logic [ADDR_W-1:0]       hit_address;
	} rec_t;

	function automatic logic [31:0] pat_value(input int idx);
		logic [31:0] v;
		unique case (idx)
			0:       v = 32'hF821FF71;
			1:       v = 32'h7C0802A6;
			2:       v = 32'h90610070;
			3:       v = 32'hF80100A0;
			4:       v = 32'h38610070;
			5:       v = 32'hE8820000;
			6:       v = 32'h38000002;
			7:       v = 32'h38A10080;
			8:       v = 32'h38C10078;
			9:       v = 32'hF8010078;
			10:      v = 32'hF8010080;
			11:      v = 32'h48000001;
			12:      v = 32'hE80100A0;
			13:      v = 32'h78630620;
			14:      v = 32'h7C0803A6;
			15:      v = 32'h38210090;
			16:      v = 32'h4E800020;
			default: v = 32'h0;
		endcase
		return v;
	endfunction

	// Words past the end of the table have mask zero and always match.
	function automatic logic [31:0] pat_mask(input int idx);
		logic [31:0] m;
		unique case (idx)
			5:       m = 32'hFFFF0000;
			11:      m = 32'hFC000003;
			default: m = (idx < 17) ? 32'hFFFFFFFF : 32'h0;
		endcase
		return m;
	endfunction

endpackage

// ----- rtl/masked_signature_scanner.sv -----
// Masked signature scanner top level: window, compare logic, hit counters
// and output register. Depends on mss_pkg.
`timescale 1ns / 1ps

// Channel   Dir   Handshake          Payload
// s_*       in    s_tvalid/s_tready  tdata: mem_qword; tlast: final_qword
// m_*       out   m_tvalid/m_tready  tdata: hit record fields; tuser: record_kind;
//                                    tlast: last record of a word
// cfg_*     in    cfg_wr_en          cfg_wr_data: start_address
//
// An input word is registered into the window on acceptance, and the next cycle
// the two candidate starts are compared; one request leaves per cycle unless the
// output stalls. A word that causes no result is retired at once, so one word per
// cycle is sustained; a word causing several results stays in the compare stage
// until its last one leaves. Reset clears the window, all counters and start_address.
// A stalled output register holds its request and any word with requests pending.

module masked_signature_scanner
	import mss_pkg::*;
#(
	parameter int MAX_HITS   = 16,
	parameter int SIG_WORDS  = 17,
	parameter int CORE_WORDS = 11
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_wr_en,
	input  logic [ADDR_W-1:0]     cfg_wr_data,   // start_address
	input  logic                  s_tvalid,
	output logic                  s_tready,
	input  logic [IN_DATA_W-1:0]  s_tdata,       // [63:0] mem_qword
	input  logic                  s_tlast,       // final_qword
	output logic                  m_tvalid,
	input  logic                  m_tready,
	// [63:0] hit_address, [64] hit_strict, [65] hit_stored, [70:66] best_index,
	// [75:71] stored_hits, [107:76] overflow_hits, [139:108] words_read, rest zero
	output logic [OUT_DATA_W-1:0] m_tdata,
	output logic [0:0]            m_tuser,       // [0] record_kind
	output logic                  m_tlast        // last record of the current word
);

	localparam int WIN      = SIG_WORDS + 1;
	localparam int CORE_EFF = (CORE_WORDS < SIG_WORDS) ? CORE_WORDS : SIG_WORDS;
	localparam int FILL_MAX = (SIG_WORDS + 2) / 2;
	localparam int FW       = $clog2(FILL_MAX + 1);
	localparam int FILL0    = (SIG_WORDS + 2) / 2;
	localparam int FILL1    = (SIG_WORDS + 1) / 2;
	localparam int HCW      = $clog2(MAX_HITS + 1);
	localparam int SLW      = (MAX_HITS > 1) ? $clog2(MAX_HITS) : 1;
	localparam logic [ADDR_W-1:0] REL_RESET = ADDR_W'(0) - ADDR_W'(4 * SIG_WORDS);

	logic [ADDR_W-1:0] start_q;
	logic [31:0]       win_q [WIN];
	logic [31:0]       win_base [WIN];
	logic [FW-1:0]     fill_q;
	logic [CNT_W-1:0]  qword_q;
	logic [ADDR_W-1:0] rel_q;
	logic [HCW-1:0]    hit_total_q, hit_n;
	logic [HCW-1:0]    strict_total_q, strict_n;
	logic [SLW-1:0]    slot_q, slot_n;
	logic [CNT_W-1:0]  ovf_q, ovf_n;
	logic              valid_s1, last_s1;
	logic [1:0]        done_q;

	logic [SIG_WORDS-1:0] eq0, eq1;
	logic        hit0, hit1, strict0, strict1;
	logic [2:0]  pend;
	logic        emit_ok, emit, single, retire, accept, clear, sel_hit, sel_strict;
	logic        stored;
	logic [ADDR_W-1:0] addr1, addr0;
	logic [31:0] hit_ext, slot_ext;
	rec_t        rec;

	// Candidate compares against the current window.
	always_comb begin
		for (int i = 0; i < SIG_WORDS; i++) begin
			eq0[i] = (win_q[i] & pat_mask(i)) == pat_value(i);
			eq1[i] = (win_q[i+1] & pat_mask(i)) == pat_value(i);
		end
		strict0 = &eq0;
		strict1 = &eq1;
		hit0 = (fill_q >= FW'(FILL0)) && (strict0 || (&eq0[CORE_EFF-1:0]));
		hit1 = (fill_q >= FW'(FILL1)) && (strict1 || (&eq1[CORE_EFF-1:0]));
	end

	// Pending requests of the word in the compare stage, served lowest first.
	assign pend    = {last_s1, hit1 & ~done_q[1], hit0 & ~done_q[0]} & {3{valid_s1}};
	assign emit_ok = !m_tvalid || m_tready;
	assign emit    = emit_ok && (pend != 3'b000);
	assign single  = ((pend & (pend - 3'd1)) == 3'b000);
	assign retire  = valid_s1 && ((pend == 3'b000) || (emit && single));
	assign s_tready = !valid_s1 || retire;
	assign accept  = s_tvalid && s_tready;
	assign clear   = retire && last_s1;

	assign sel_hit    = pend[0] || pend[1];
	assign sel_strict = pend[0] ? strict0 : strict1;
	assign addr1      = start_q + rel_q;
	assign addr0      = addr1 - ADDR_W'(4);

	always_comb begin
		hit_n    = hit_total_q;
		strict_n = strict_total_q;
		slot_n   = slot_q;
		ovf_n    = ovf_q;
		stored   = 1'b0;
		if (sel_hit) begin
			if (hit_total_q < HCW'(MAX_HITS)) begin
				stored = 1'b1;
				hit_n  = hit_total_q + HCW'(1);
				if (sel_strict) begin
					strict_n = strict_total_q + HCW'(1);
					slot_n   = SLW'(hit_total_q);
				end
			end else if (ovf_q != '1) begin
				ovf_n = ovf_q + CNT_W'(1);
			end
		end
		hit_ext  = 32'(hit_n);
		slot_ext = 32'(slot_n);

		rec.hit_address   = sel_hit ? (pend[0] ? addr0 : addr1) : '0;
		rec.hit_strict    = sel_hit && sel_strict;
		rec.hit_stored    = stored;
		rec.best_index    = (strict_n == HCW'(1)) ? slot_ext[IDX_W-1:0] : '1;
		rec.stored_hits   = hit_ext[IDX_W-1:0];
		rec.overflow_hits = ovf_n;
		rec.words_read    = qword_q;

		// After the final word the next one shifts into an empty window.
		for (int i = 0; i < WIN; i++) begin
			win_base[i] = clear ? 32'h0 : win_q[i];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			start_q <= '0;
		end else if (cfg_wr_en) begin
			start_q <= cfg_wr_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < WIN; i++) win_q[i] <= '0;
			fill_q  <= '0;
			qword_q <= '0;
			rel_q   <= REL_RESET;
		end else if (accept) begin
			for (int i = 0; i < WIN - 2; i++) win_q[i] <= win_base[i+2];
			win_q[WIN-2] <= s_tdata[63:32];
			win_q[WIN-1] <= s_tdata[31:0];
			if (clear) begin
				fill_q  <= FW'(1);
				qword_q <= CNT_W'(1);
				rel_q   <= REL_RESET + ADDR_W'(8);
			end else begin
				if (fill_q != FW'(FILL_MAX)) fill_q <= fill_q + FW'(1);
				if (qword_q != '1) qword_q <= qword_q + CNT_W'(1);
				rel_q <= rel_q + ADDR_W'(8);
			end
		end else if (clear) begin
			for (int i = 0; i < WIN; i++) win_q[i] <= '0;
			fill_q  <= '0;
			qword_q <= '0;
			rel_q   <= REL_RESET;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hit_total_q    <= '0;
			strict_total_q <= '0;
			slot_q         <= '0;
			ovf_q          <= '0;
		end else if (clear) begin
			hit_total_q    <= '0;
			strict_total_q <= '0;
			slot_q         <= '0;
			ovf_q          <= '0;
		end else if (emit) begin
			hit_total_q    <= hit_n;
			strict_total_q <= strict_n;
			slot_q         <= slot_n;
			ovf_q          <= ovf_n;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			last_s1  <= 1'b0;
			done_q   <= '0;
		end else begin
			if (accept) begin
				valid_s1 <= 1'b1;
				last_s1  <= s_tlast;
			end else if (retire) begin
				valid_s1 <= 1'b0;
			end
			if (retire) begin
				done_q <= '0;
			end else if (emit) begin
				done_q <= done_q | pend[1:0] & (pend[0] ? 2'b01 : 2'b10);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid <= 1'b0;
		end else if (emit_ok) begin
			m_tvalid <= emit;
		end
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			m_tdata    <= {(OUT_DATA_W - REC_W)'(0), rec};
			m_tuser[0] <= sel_hit ? REC_KIND_HIT : REC_KIND_SUMMARY;
			m_tlast    <= single;
		end
	end

endmodule
